// File: hdl/etl_pkg.sv
// Shared types, character codes and helpers for the expression token lexer.
// No dependencies; the core, queue, top level and testbench import this package.
`timescale 1ns / 1ps

package etl_pkg;

  localparam int unsigned MAX_LENGTH_DEFAULT = 255;
  localparam int unsigned QUEUE_DEPTH        = 4;
  localparam int unsigned QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_MINUS      = 8'd45;
  localparam logic [7:0] CH_DOT        = 8'd46;
  localparam logic [7:0] CH_UPPER_E    = 8'd69;
  localparam logic [7:0] CH_LOWER_E    = 8'd101;
  localparam logic [7:0] CH_LPAREN     = 8'd40;
  localparam logic [7:0] CH_RPAREN     = 8'd41;
  localparam logic [7:0] CH_STAR       = 8'd42;
  localparam logic [7:0] CH_PLUS       = 8'd43;
  localparam logic [7:0] CH_SLASH      = 8'd47;
  localparam logic [7:0] CH_CARET      = 8'd94;
  localparam logic [7:0] CH_EQUALS     = 8'd61;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_INT     = 3'd1,
    MODE_REAL    = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_MINUS   = 3'd4,
    MODE_SLASH   = 3'd5,
    MODE_COMMENT = 3'd6
  } mode_t;

  typedef enum logic [3:0] {
    KIND_INT     = 4'd0,
    KIND_REAL    = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_LPAREN  = 4'd3,
    KIND_RPAREN  = 4'd4,
    KIND_MUL     = 4'd5,
    KIND_ADD     = 4'd6,
    KIND_SUB     = 4'd7,
    KIND_DIV     = 4'd8,
    KIND_POW     = 4'd9,
    KIND_ASSIGN  = 4'd10,
    KIND_INVALID = 4'd11
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] length;
    logic       last;
  } result_t;

  // Results caused by one character: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'd65:8'd90], [8'd97:8'd122]};
  endfunction

  // Modes that hold a token still waiting to be reported.
  function automatic logic mode_open(input mode_t m);
    return m inside {MODE_INT, MODE_REAL, MODE_IDENT, MODE_MINUS, MODE_SLASH};
  endfunction

endpackage

// File: hdl/etl_if.sv
// Channel interfaces of the expression token lexer: characters in, tokens out.
// Does not depend on etl_pkg; payload widths are fixed.
`timescale 1ns / 1ps

interface etl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface etl_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] token_length;
  logic       last;

  modport source (output valid, output token_kind, output token_length, output last,
                  input ready);
  modport sink (input valid, input token_kind, input token_length, input last,
                output ready);
endinterface

// File: hdl/etl_lex_core.sv
// Lexer state (mode and run length) and the per-character decision logic.
// Depends on etl_pkg; produces up to two token results per accepted character.
`timescale 1ns / 1ps

module etl_lex_core
  import etl_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       line_end,
  output step_t      step
);

  localparam int unsigned RUN_W = $clog2(MAX_LENGTH + 1);

  mode_t             mode, mode_next;
  logic [RUN_W-1:0]  run_length, run_length_next;

  logic [RUN_W-1:0]  run_grown;
  logic              extend;
  mode_t             mid_mode;
  logic [RUN_W-1:0]  mid_run;
  logic              a_valid, b_valid, c_valid;
  result_t           a_res, b_res, c_res, second_res;

  function automatic logic [7:0] cap_length(input logic [RUN_W-1:0] r);
    logic [RUN_W+7:0] wide;
    wide = (RUN_W + 8)'(r);
    return (wide > (RUN_W + 8)'(255)) ? 8'hFF : wide[7:0];
  endfunction

  function automatic result_t flush_result(input mode_t m, input logic [RUN_W-1:0] r);
    result_t res;
    res.last = 1'b0;
    res.length = cap_length(r);
    case (m)
      MODE_INT:   res.kind = KIND_INT;
      MODE_REAL:  res.kind = KIND_REAL;
      MODE_IDENT: res.kind = KIND_IDENT;
      MODE_MINUS: begin
        res.kind = KIND_SUB;
        res.length = 8'd1;
      end
      MODE_SLASH: begin
        res.kind = KIND_DIV;
        res.length = 8'd1;
      end
      default: begin
        res.kind = KIND_INVALID;
        res.length = 8'd1;
      end
    endcase
    return res;
  endfunction

  assign run_grown = (RUN_W'(MAX_LENGTH) > run_length) ? run_length + 1'b1 : run_length;

  always_comb begin
    extend   = 1'b0;
    mid_mode = mode;
    mid_run  = run_length;
    b_valid  = 1'b0;
    b_res    = '{kind: KIND_INVALID, length: 8'd1, last: 1'b0};

    // Does the character extend the open token?
    case (mode)
      MODE_INT: begin
        if (is_digit(char_code)) begin
          extend  = 1'b1;
          mid_run = run_grown;
        end else if (char_code == CH_DOT) begin
          extend   = 1'b1;
          mid_run  = run_grown;
          mid_mode = MODE_REAL;
        end
      end
      MODE_REAL: begin
        if (is_digit(char_code) || char_code inside {CH_DOT, CH_MINUS, CH_UPPER_E,
                                                     CH_LOWER_E}) begin
          extend  = 1'b1;
          mid_run = run_grown;
        end
      end
      MODE_IDENT: begin
        if (is_letter(char_code) || is_digit(char_code) || char_code == CH_UNDERSCORE) begin
          extend  = 1'b1;
          mid_run = run_grown;
        end
      end
      MODE_MINUS: begin
        if (is_digit(char_code)) begin
          extend   = 1'b1;
          mid_mode = MODE_INT;
          mid_run  = RUN_W'(2);
        end
      end
      MODE_SLASH: begin
        if (char_code == CH_SLASH) begin
          extend   = 1'b1;
          mid_mode = MODE_COMMENT;
          mid_run  = '0;
        end
      end
      MODE_COMMENT: extend = 1'b1;
      default:      extend = 1'b0;
    endcase

    // The open token closes and the character starts fresh.
    a_valid = !extend && mode_open(mode);
    a_res   = flush_result(mode, run_length);

    if (!extend) begin
      mid_run = RUN_W'(1);
      if (is_digit(char_code)) begin
        mid_mode = MODE_INT;
      end else if (char_code == CH_DOT) begin
        mid_mode = MODE_REAL;
      end else if (is_letter(char_code)) begin
        mid_mode = MODE_IDENT;
      end else if (char_code == CH_MINUS) begin
        mid_mode = MODE_MINUS;
      end else if (char_code == CH_SLASH) begin
        mid_mode = MODE_SLASH;
      end else begin
        mid_mode = MODE_IDLE;
        mid_run  = '0;
        b_valid  = (char_code != CH_SPACE);
        case (char_code)
          CH_LPAREN: b_res.kind = KIND_LPAREN;
          CH_RPAREN: b_res.kind = KIND_RPAREN;
          CH_STAR:   b_res.kind = KIND_MUL;
          CH_PLUS:   b_res.kind = KIND_ADD;
          CH_CARET:  b_res.kind = KIND_POW;
          CH_EQUALS: b_res.kind = KIND_ASSIGN;
          default:   b_res.kind = KIND_INVALID;
        endcase
      end
    end

    // Line end reports whatever is still open.
    c_valid = line_end && mode_open(mid_mode);
    c_res   = flush_result(mid_mode, mid_run);

    if (line_end) begin
      mode_next       = MODE_IDLE;
      run_length_next = '0;
    end else begin
      mode_next       = mid_mode;
      run_length_next = mid_run;
    end
  end

  // A start emission leaves the lexer idle, so it never meets a line-end flush.
  assign second_res = b_valid ? b_res : c_res;

  always_comb begin
    step.count  = 2'(a_valid) + 2'(b_valid || c_valid);
    step.first  = a_valid ? a_res : second_res;
    step.second = second_res;
    if (a_valid && (b_valid || c_valid)) begin
      step.second.last = 1'b1;
    end else begin
      step.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      run_length <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      run_length <= run_length_next;
    end
  end

endmodule

// File: hdl/etl_result_queue.sv
// Small result queue: takes up to two results a cycle and hands out one a cycle when popped.
// Depends on etl_pkg for result_t, step_t and the queue depth.
`timescale 1ns / 1ps

module etl_result_queue
  import etl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  step_t   step,
  input  logic    pop,
  output logic    has_room,
  output logic    out_valid,
  output result_t out_data
);

  result_t                entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count, count_next;
  logic [1:0]             push_count;
  logic                   do_pop;

  assign push_count = push ? step.count : 2'd0;
  assign do_pop     = pop && (count != '0);
  assign count_next = count + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(do_pop);

  assign has_room  = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= step.first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= step.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_W'(push_count);
      rd_ptr <= rd_ptr + QUEUE_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

// File: hdl/expression_token_lexer.sv
// Top level of the expression token lexer: character channel in, token channel out.
// Depends on etl_pkg, etl_if, etl_lex_core and etl_result_queue.
`timescale 1ns / 1ps

// Usage
// The chars channel carries one ASCII character per beat, with line_end set on
// the last character of each line. The tokens channel carries one token per beat:
// its kind, its length (saturating at MAX_LENGTH, reported at most 255) and a last
// flag set on the final token caused by a given character. A character causes zero,
// one or two tokens; a token is reported when the first character that cannot
// extend it arrives, or at line end.
// The tokens caused by a character are written into the result queue as its beat is taken.
// Throughput: one character per cycle while the tokens drain as fast as they are
// made. The lexer decision is one pass of combinational logic into a four-entry
// result queue; chars.ready stays high while the queue has room for two tokens.
// A character that causes two tokens therefore fills the queue faster than the token side drains it.
// When the receiver stalls, tokens wait in the queue and chars.ready drops once
// fewer than two slots remain. Reset (rst, synchronous) empties the queue and puts
// the lexer between tokens with no run open.
module expression_token_lexer
  import etl_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  etl_char_if.sink    chars,
  etl_token_if.source tokens
);

  step_t   step;
  logic    accept;
  logic    has_room;
  result_t head;

  assign chars.ready = has_room;
  assign accept      = chars.valid && has_room;

  etl_lex_core #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (chars.char_code),
    .line_end  (chars.line_end),
    .step      (step)
  );

  // The queue decouples the two sides so a stalled receiver does not stop
  // characters until the queue is nearly full.
  etl_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .step      (step),
    .pop       (tokens.ready),
    .has_room  (has_room),
    .out_valid (tokens.valid),
    .out_data  (head)
  );

  assign tokens.token_kind   = head.kind;
  assign tokens.token_length = head.length;
  assign tokens.last         = head.last;

endmodule

// File: hdl/etl_checker.sv
// Port-level checks of the expression token lexer, bound to the top level.
// Depends on expression_token_lexer and the etl channel interfaces.
`timescale 1ns / 1ps

module etl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_kind,
  input logic [7:0] out_length,
  input logic       out_last
);

  // A stalled token holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_length)
      && $stable(out_last))
    else $error("stalled token changed");

  // Tokens only appear on an empty token side after a character beat was taken.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("token appeared without a character beat");

  // A token that is not the last of its character is followed by another.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second token of a character missing");

  // Reset leaves nothing to deliver.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token visible after reset");

endmodule

bind expression_token_lexer etl_checker u_etl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (chars.valid),
  .in_ready   (chars.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_length (tokens.token_length),
  .out_last   (tokens.last)
);

// File: verif/tb_expression_token_lexer.sv
// Self-checking testbench for the expression token lexer.
// Depends on etl_pkg, etl_if and the expression_token_lexer RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_expression_token_lexer;
  import etl_pkg::*;

  // Run length at which a token stops growing; the block is built with its default.
  localparam int unsigned LEN_CAP = MAX_LENGTH_DEFAULT;
  // Random lines are generated until this many characters, comment text apart, are queued.
  localparam int unsigned RANDOM_CHARS = 1200;
  // Length of the one long stretch in which the token side refuses every beat.
  localparam int unsigned HOLD_CYCLES = 200;
  // Idle chance, in percent, on either side outside the calm window.
  localparam int unsigned IDLE_PCT = 34;
  // Cycles allowed after the last expected token before the verdict.
  localparam int unsigned TAIL_CYCLES = 20;

  // One character waiting to be sent. With wait_drain set, the sender holds it back
  // until every token predicted so far has come out of the block.
  typedef struct {
    logic [7:0] code;
    logic       eol;
    logic       wait_drain;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  etl_char_if  char_ch ();
  etl_token_if token_ch ();

  expression_token_lexer DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (char_ch),
    .tokens (token_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token predictor. It keeps its own copy of the lexer mode and of the length of
  // the open run, and turns each accepted character into the tokens it causes.
  // ---------------------------------------------------------------------------
  mode_t       lex_mode = MODE_IDLE;
  int unsigned run_len  = 0;
  result_t     step_tokens[$];   // tokens caused by the character being lexed
  result_t     tokens_due[$];    // predicted tokens not yet seen on the token side

  char_beat_t  chars_to_send[$];
  logic [7:0]  line_buf[$];
  int unsigned useful_chars = 0;  // random characters that are not comment text
  int unsigned error_count  = 0;
  int unsigned chars_taken  = 0;
  logic        char_took    = 1'b0;
  logic        calm;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;

  function automatic logic char_is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void note_token(input kind_t k, input int unsigned len);
    result_t r;
    r.kind   = k;
    // The run itself saturates at LEN_CAP; the reported field holds at most 255.
    r.length = (len > 255) ? 8'd255 : 8'(len);
    r.last   = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void extend_run();
    if (run_len < LEN_CAP) run_len++;
  endfunction

  // A character seen with no token open opens a run, is a token by itself, or (a space) is dropped.
  function automatic void open_token(input logic [7:0] c);
    run_len = 1;
    if (char_is_numeral(c)) begin
      lex_mode = MODE_INT;
    end else if (c == CH_DOT) begin
      lex_mode = MODE_REAL;
    end else if (char_is_alpha(c)) begin
      lex_mode = MODE_IDENT;
    end else if (c == CH_MINUS) begin
      lex_mode = MODE_MINUS;
    end else if (c == CH_SLASH) begin
      lex_mode = MODE_SLASH;
    end else begin
      lex_mode = MODE_IDLE;
      run_len  = 0;
      case (c)
        CH_LPAREN: note_token(KIND_LPAREN, 1);
        CH_RPAREN: note_token(KIND_RPAREN, 1);
        CH_STAR:   note_token(KIND_MUL, 1);
        CH_PLUS:   note_token(KIND_ADD, 1);
        CH_CARET:  note_token(KIND_POW, 1);
        CH_EQUALS: note_token(KIND_ASSIGN, 1);
        CH_SPACE:  ;
        default:   note_token(KIND_INVALID, 1);
      endcase
    end
  endfunction

  // Reports whatever is open, including a held minus or slash, and goes idle.
  function automatic void close_token();
    case (lex_mode)
      MODE_INT:   note_token(KIND_INT, run_len);
      MODE_REAL:  note_token(KIND_REAL, run_len);
      MODE_IDENT: note_token(KIND_IDENT, run_len);
      MODE_MINUS: note_token(KIND_SUB, 1);
      MODE_SLASH: note_token(KIND_DIV, 1);
      default:    ;
    endcase
    lex_mode = MODE_IDLE;
    run_len  = 0;
  endfunction

  function automatic void lex_char(input logic [7:0] c, input logic eol);
    step_tokens.delete();
    case (lex_mode)
      MODE_INT: begin
        // A dot turns the integer into a real; a minus ends it.
        if (char_is_numeral(c)) begin
          extend_run();
        end else if (c == CH_DOT) begin
          extend_run();
          lex_mode = MODE_REAL;
        end else begin
          close_token();
          open_token(c);
        end
      end
      MODE_REAL: begin
        if (char_is_numeral(c) || c == CH_DOT || c == CH_MINUS ||
            c == CH_UPPER_E || c == CH_LOWER_E) begin
          extend_run();
        end else begin
          close_token();
          open_token(c);
        end
      end
      MODE_IDENT: begin
        if (char_is_alpha(c) || char_is_numeral(c) || c == CH_UNDERSCORE) begin
          extend_run();
        end else begin
          close_token();
          open_token(c);
        end
      end
      MODE_MINUS: begin
        // A digit right after a minus starts a signed integer whose run holds both characters.
        if (char_is_numeral(c)) begin
          lex_mode = MODE_INT;
          run_len  = 1;
          extend_run();
        end else begin
          close_token();
          open_token(c);
        end
      end
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_COMMENT;
          run_len  = 0;
        end else begin
          close_token();
          open_token(c);
        end
      end
      MODE_COMMENT: ;
      default: open_token(c);
    endcase
    if (eol) close_token();
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------
  function automatic void push_char(input logic [7:0] c, input logic eol,
                                    input logic wait_drain);
    char_beat_t b;
    b.code       = c;
    b.eol        = eol;
    b.wait_drain = wait_drain;
    chars_to_send.push_back(b);
  endfunction

  function automatic void push_text(input string s, input logic eol_at_end);
    for (int i = 0; i < s.len(); i++) push_char(s[i], eol_at_end && i == s.len() - 1, 1'b0);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(0, 3))
      0, 1: return rand_letter();
      2:    return rand_digit();
      default: return CH_UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 7))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_STAR;
      3: return CH_PLUS;
      4: return CH_MINUS;
      5: return CH_SLASH;
      6: return CH_CARET;
      default: return CH_EQUALS;
    endcase
  endfunction

  // A run long enough to push the length past its saturation point.
  function automatic void add_long_run();
    int unsigned len;
    len = $urandom_range(LEN_CAP + 1, LEN_CAP + 45);
    case ($urandom_range(0, 2))
      0: begin
        line_buf.push_back(rand_letter());
        repeat (len - 1) line_buf.push_back(rand_name_char());
      end
      1: begin
        line_buf.push_back(CH_MINUS);
        repeat (len - 1) line_buf.push_back(rand_digit());
      end
      default: begin
        line_buf.push_back(CH_DOT);
        repeat (len - 1) line_buf.push_back(rand_digit());
      end
    endcase
  endfunction

  // Builds one line into line_buf: mostly well-formed tokens with random content, with
  // stray bytes, broken numbers and trailing comments mixed in; some lines are pure noise.
  function automatic void build_line(input logic with_long);
    int unsigned n_tok;
    int unsigned body;
    logic        closed;
    line_buf.delete();
    closed = 1'b0;
    if (with_long) add_long_run();
    if ($urandom_range(0, 9) == 0) begin
      // Pure noise line.
      repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
      useful_chars += line_buf.size();
      return;
    end
    n_tok = $urandom_range(1, 8);
    for (int t = 0; t < n_tok && !closed; t++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_MINUS);
          repeat ($urandom_range(1, 6)) line_buf.push_back(rand_digit());
        end
        2, 3: begin
          repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
          line_buf.push_back(CH_DOT);
          repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
          if ($urandom_range(0, 1)) begin
            line_buf.push_back($urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E);
            if ($urandom_range(0, 1)) line_buf.push_back(CH_MINUS);
            repeat ($urandom_range(0, 2)) line_buf.push_back(rand_digit());
          end
        end
        4, 5: begin
          line_buf.push_back(rand_letter());
          repeat ($urandom_range(0, 6)) line_buf.push_back(rand_name_char());
        end
        6, 7: line_buf.push_back(rand_operator());
        8: begin
          // Comment to the end of the line; its text is ignored by the lexer.
          line_buf.push_back(CH_SLASH);
          line_buf.push_back(CH_SLASH);
          body = $urandom_range(0, 5);
          repeat (body) line_buf.push_back(8'($urandom_range(0, 255)));
          useful_chars -= body;
          closed = 1'b1;
        end
        default: line_buf.push_back(8'($urandom_range(0, 255)));
      endcase
      if (!closed && $urandom_range(0, 1)) line_buf.push_back(CH_SPACE);
    end
    useful_chars += line_buf.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Character driver. The beat is taken at the rising edge, where the predictor
  // runs on the values actually on the bus; the next beat is set up at the falling
  // edge. A beat that was offered stays on the bus, unchanged, until it is taken.
  // ---------------------------------------------------------------------------
  assign calm = chars_taken >= 700 && chars_taken < 1100;

  always @(posedge clk) begin
    char_took = !rst && char_ch.valid && char_ch.ready;
    if (char_took) begin
      lex_char(char_ch.char_code, char_ch.line_end);
      void'(chars_to_send.pop_front());
      chars_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      char_ch.valid <= 1'b0;
    end else if (!char_ch.valid || char_took) begin
      if (chars_to_send.size() == 0 ||
          (chars_to_send[0].wait_drain && tokens_due.size() != 0) ||
          (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
        char_ch.valid <= 1'b0;
      end else begin
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= chars_to_send[0].code;
        char_ch.line_end  <= chars_to_send[0].eol;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Token side. Ready is dropped at random, except in the calm window. Once, after
  // a few hundred characters have gone in, it is held low for the HOLD_CYCLES stretch
  // while the sender keeps offering, so the result queue fills and the character
  // side is stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      token_ch.ready <= 1'b0;
    end else if (!hold_done && chars_taken >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      token_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      token_ch.ready <= 1'b0;
    end else begin
      token_ch.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("%0t ns: token mismatch: %s", $time, what);
    error_count++;
  endtask

  // Every token beat is checked against the oldest prediction, field by field.
  always @(posedge clk) begin : check_tokens
    result_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d length %0d",
                                  token_ch.token_kind, token_ch.token_length));
      end else begin
        want = tokens_due.pop_front();
        if (token_ch.token_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, predicted %0d",
                                    token_ch.token_kind, want.kind));
        if (token_ch.token_length !== want.length)
          report_mismatch($sformatf("length %0d, predicted %0d",
                                    token_ch.token_length, want.length));
        if (token_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, predicted %0b", token_ch.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed lines, random lines, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned line_no;
    char_ch.valid     = 1'b0;
    char_ch.char_code = 8'd0;
    char_ch.line_end  = 1'b0;
    token_ch.ready    = 1'b0;

    // Directed line: identifier with underscore and digit, assign, a signed integer
    // ended by a minus, minus then dot, a real taking e, E and minus that is closed
    // by a paren (two tokens from one character), every operator, a lone slash,
    // and a comment that runs to the line end.
    push_text("a_9=-7-.5eE-()*+^/ //q", 1'b1);
    // Lone underscore, the lowest and highest bytes, and a minus held at line end.
    push_char(CH_UNDERSCORE, 1'b0, 1'b0);
    push_char(8'd0, 1'b0, 1'b0);
    push_char(8'd255, 1'b1, 1'b0);
    push_char(CH_MINUS, 1'b1, 1'b0);

    // Random lines. A few carry runs past the length cap, and the first random line
    // and line 60, if built, start only after everything before them has come out.
    line_no = 0;
    while (useful_chars < RANDOM_CHARS) begin
      build_line(line_no % 40 == 13);
      foreach (line_buf[i])
        push_char(line_buf[i], i == line_buf.size() - 1,
                  i == 0 && (line_no == 0 || line_no == 60));
      line_no++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (chars_to_send.size() != 0) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_expression_token_lexer: done, clean");
    end else begin
      $display("tb_expression_token_lexer: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_expression_token_lexer: done, errors");
    $finish;
  end

endmodule
